// ----- rtl/ptrp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrp_pkg
// Shared types and constants of the paper-tape reader/punch controller.
// ----------------------------------------------------------------------------
package ptrp_pkg;

  localparam int unsigned OpW    = 4;
  localparam int unsigned AcW    = 12;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned DelayW = 8;

  localparam logic [DelayW-1:0] DelayReset = 8'd20;
  localparam logic [ByteW-1:0]  PunchMask  = 8'o377;

  // I/O instruction and event codes
  typedef enum logic [OpW-1:0] {
    OP_TICK        = 4'd0,
    OP_BYTE_IN     = 4'd1,
    OP_INTR_ENABLE = 4'd2,
    OP_READER_SKIP = 4'd3,
    OP_READ        = 4'd4,
    OP_FETCH       = 4'd5,
    OP_READ_FETCH  = 4'd6,
    OP_INTR_DIS    = 4'd7,
    OP_PUNCH_SKIP  = 4'd8,
    OP_PUNCH_CLEAR = 4'd9,
    OP_PUNCH       = 4'd10,
    OP_CLEAR_PUNCH = 4'd11,
    OP_DEV_CLEAR   = 4'd12
  } ptrp_op_e;

  typedef struct packed {
    logic [OpW-1:0]   opcode;
    logic [AcW-1:0]   ac_in;
    logic [ByteW-1:0] reader_char;
  } ptrp_item_t;

  typedef struct packed {
    logic             skip;
    logic             ac_write;
    logic [AcW-1:0]   ac_out;
    logic             punch_valid;
    logic [ByteW-1:0] punch_byte;
    logic             reader_request;
    logic             reader_rejected;
    logic             irq_reader;
    logic             irq_punch;
  } ptrp_result_t;

endpackage

// ----- rtl/ptrp_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrp_in_stage
// Input register: holds one accepted item until the core consumes it.
// ----------------------------------------------------------------------------
module ptrp_in_stage
  import ptrp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  ptrp_item_t item_i,
  input  logic       advance_i,
  output logic       valid_o,
  output ptrp_item_t item_o
);

  logic       valid_q, valid_d;
  ptrp_item_t item_q;
  logic       load;

  // Take a new item when empty or when the held one moves on this cycle
  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture payload on transfer
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- rtl/ptrp_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrp_core
// Device state (flags, enable, buffer, countdowns, delay register) and the
// per-instruction update and result logic.
// ----------------------------------------------------------------------------
module ptrp_core
  import ptrp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [DelayW-1:0] cfg_wdata_i,
  input  logic              advance_i,
  input  ptrp_item_t        item_i,
  output ptrp_result_t      result_o
);

  logic              reader_flag_q, reader_flag_d;
  logic              punch_flag_q, punch_flag_d;
  logic              intr_en_q, intr_en_d;
  logic [ByteW-1:0]  rbuf_q, rbuf_d;
  logic [DelayW-1:0] punch_cnt_q, punch_cnt_d;
  logic [DelayW-1:0] fetch_cnt_q, fetch_cnt_d;
  logic [DelayW-1:0] delay_q;
  logic [DelayW-1:0] load_val;
  logic [DelayW-1:0] punch_dec;
  logic [DelayW-1:0] fetch_dec;

  // A zero delay behaves as one tick
  assign load_val  = (delay_q == '0) ? DelayW'(1) : delay_q;
  assign punch_dec = punch_cnt_q - DelayW'(1);
  assign fetch_dec = fetch_cnt_q - DelayW'(1);

  // Next state and result for the held instruction
  always_comb begin
    reader_flag_d = reader_flag_q;
    punch_flag_d  = punch_flag_q;
    intr_en_d     = intr_en_q;
    rbuf_d        = rbuf_q;
    punch_cnt_d   = punch_cnt_q;
    fetch_cnt_d   = fetch_cnt_q;

    result_o                 = '0;
    result_o.ac_out          = item_i.ac_in;

    unique case (item_i.opcode)
      OP_TICK: begin
        if (punch_cnt_q != '0) begin
          punch_cnt_d = punch_dec;
          if (punch_dec == '0) begin
            punch_flag_d = 1'b1;
          end
        end
        if (fetch_cnt_q != '0) begin
          fetch_cnt_d = fetch_dec;
          if (fetch_dec == '0) begin
            result_o.reader_request = 1'b1;
          end
        end
      end
      OP_BYTE_IN: begin
        if (reader_flag_q) begin
          result_o.reader_rejected = 1'b1;
        end else begin
          rbuf_d        = item_i.reader_char;
          reader_flag_d = 1'b1;
        end
      end
      OP_INTR_ENABLE: intr_en_d = 1'b1;
      OP_READER_SKIP: result_o.skip = reader_flag_q;
      OP_READ, OP_READ_FETCH: begin
        result_o.ac_write = 1'b1;
        result_o.ac_out   = item_i.ac_in | {{(AcW-ByteW){1'b0}}, rbuf_q};
        reader_flag_d     = 1'b0;
        if (item_i.opcode == OP_READ_FETCH) begin
          fetch_cnt_d = load_val;
        end
      end
      OP_FETCH: begin
        reader_flag_d = 1'b0;
        fetch_cnt_d   = load_val;
      end
      OP_INTR_DIS:    intr_en_d = 1'b0;
      OP_PUNCH_SKIP:  result_o.skip = punch_flag_q;
      OP_PUNCH_CLEAR: punch_flag_d = 1'b0;
      OP_PUNCH, OP_CLEAR_PUNCH: begin
        if (item_i.opcode == OP_CLEAR_PUNCH) begin
          punch_flag_d = 1'b0;
        end
        result_o.punch_valid = 1'b1;
        result_o.punch_byte  = item_i.ac_in[ByteW-1:0] & PunchMask;
        punch_cnt_d          = load_val;
      end
      OP_DEV_CLEAR: begin
        reader_flag_d = 1'b0;
        punch_flag_d  = 1'b0;
        intr_en_d     = 1'b1;
      end
      default: ;
    endcase

    result_o.irq_reader = reader_flag_d & intr_en_d;
    result_o.irq_punch  = punch_flag_d & intr_en_d;
  end

  // Commit state when the instruction moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reader_flag_q <= 1'b0;
      punch_flag_q  <= 1'b0;
      intr_en_q     <= 1'b1;
      rbuf_q        <= '0;
      punch_cnt_q   <= '0;
      fetch_cnt_q   <= '0;
    end else if (advance_i) begin
      reader_flag_q <= reader_flag_d;
      punch_flag_q  <= punch_flag_d;
      intr_en_q     <= intr_en_d;
      rbuf_q        <= rbuf_d;
      punch_cnt_q   <= punch_cnt_d;
      fetch_cnt_q   <= fetch_cnt_d;
    end
  end

  // Delay register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DelayReset;
    end else if (cfg_we_i) begin
      delay_q <= cfg_wdata_i;
    end
  end

endmodule

// ----- rtl/ptrp_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrp_out_stage
// Result register: holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
module ptrp_out_stage
  import ptrp_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_valid_i,
  output logic         load_ready_o,
  input  ptrp_result_t result_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output ptrp_result_t result_o
);

  logic         valid_q, valid_d;
  ptrp_result_t result_q;
  logic         load;

  // Free when empty or when the held result transfers this cycle
  assign load_ready_o = !valid_q || out_ready_i;
  assign load         = load_valid_i && load_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

// ----- rtl/paper_tape_reader_punch_iot.sv -----
`timescale 1ns / 1ps
// Path: an instruction is captured in the input register, then its result in the
//   result register, from which it is presented.
// Throughput: one instruction per cycle while the result side does not stall.
// Reset: asynchronous active low; flags clear, interrupts enabled, buffer and
//   countdowns zero, delay register 20; both stages empty.
// ----------------------------------------------------------------------------
// paper_tape_reader_punch_iot
// Paper-tape reader/punch controller: flags, interrupt enable, reader buffer,
// punch and fetch countdowns, driven by I/O instructions and ticks.
// ----------------------------------------------------------------------------
module paper_tape_reader_punch_iot
  import ptrp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [DelayW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [OpW-1:0]    opcode_i,
  input  logic [AcW-1:0]    ac_in_i,
  input  logic [ByteW-1:0]  reader_char_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              skip_o,
  output logic              ac_write_o,
  output logic [AcW-1:0]    ac_out_o,
  output logic              punch_valid_o,
  output logic [ByteW-1:0]  punch_byte_o,
  output logic              reader_request_o,
  output logic              reader_rejected_o,
  output logic              irq_reader_o,
  output logic              irq_punch_o
);

  ptrp_item_t   in_item;
  ptrp_item_t   held_item;
  logic         held_valid;
  logic         out_free;
  logic         advance;
  ptrp_result_t core_result;
  ptrp_result_t out_result;

  assign in_item.opcode      = opcode_i;
  assign in_item.ac_in       = ac_in_i;
  assign in_item.reader_char = reader_char_i;

  // Move the held instruction on when the result register can take it
  assign advance = held_valid && out_free;

  ptrp_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  ptrp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (advance),
    .item_i      (held_item),
    .result_o    (core_result)
  );

  ptrp_out_stage u_out_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_valid_i (held_valid),
    .load_ready_o (out_free),
    .result_i     (core_result),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (out_result)
  );

  assign skip_o            = out_result.skip;
  assign ac_write_o        = out_result.ac_write;
  assign ac_out_o          = out_result.ac_out;
  assign punch_valid_o     = out_result.punch_valid;
  assign punch_byte_o      = out_result.punch_byte;
  assign reader_request_o  = out_result.reader_request;
  assign reader_rejected_o = out_result.reader_rejected;
  assign irq_reader_o      = out_result.irq_reader;
  assign irq_punch_o       = out_result.irq_punch;

endmodule

// ----- rtl/ptrp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptrp_checker
// Port-level checks for the reader/punch controller, bound to the top level.
// ----------------------------------------------------------------------------
module ptrp_checker
  import ptrp_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              skip_o,
  input logic              ac_write_o,
  input logic [AcW-1:0]    ac_out_o,
  input logic              punch_valid_o,
  input logic [ByteW-1:0]  punch_byte_o,
  input logic              reader_request_o,
  input logic              reader_rejected_o,
  input logic              irq_reader_o,
  input logic              irq_punch_o
);

  // Stalled result holds until transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ac_out_o)
      && $stable(punch_byte_o) && $stable(irq_reader_o) && $stable(irq_punch_o))
    else $error("result changed while stalled");

  // An empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // At most one instruction effect is reported per result
  a_one_effect: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({skip_o, ac_write_o, punch_valid_o,
      reader_request_o, reader_rejected_o}) <= 1)
    else $error("conflicting result flags");

  // Punch byte is zero unless a punch is issued
  a_punch_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !punch_valid_o |-> punch_byte_o == '0)
    else $error("punch byte without punch");

endmodule

bind paper_tape_reader_punch_iot ptrp_checker u_ptrp_checker (.*);

// ----- bench/paper_tape_reader_punch_iot_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paper_tape_reader_punch_iot_checker
// Watches the instruction, result and delay-register ports of the reader/punch
// controller. It keeps its own copy of the flags, buffer and countdowns, works
// out the result of every instruction transfer, and compares each result
// transfer with the oldest prediction still due.
// ----------------------------------------------------------------------------
module paper_tape_reader_punch_iot_checker
  import ptrp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [DelayW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  logic [OpW-1:0]    opcode_i,
  input  logic [AcW-1:0]    ac_in_i,
  input  logic [ByteW-1:0]  reader_char_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  logic              skip_i,
  input  logic              ac_write_i,
  input  logic [AcW-1:0]    ac_out_i,
  input  logic              punch_valid_i,
  input  logic [ByteW-1:0]  punch_byte_i,
  input  logic              reader_request_i,
  input  logic              reader_rejected_i,
  input  logic              irq_reader_i,
  input  logic              irq_punch_i,
  output int                fail_count_o,
  output int                pending_o
);

  localparam int ReportLimit = 10;

  // Shadow of the controller state
  logic [DelayW-1:0] event_delay_q;
  logic              reader_flag_q;
  logic              punch_flag_q;
  logic              intr_enable_q;
  logic [ByteW-1:0]  reader_buffer_q;
  logic [DelayW-1:0] punch_count_q;
  logic [DelayW-1:0] fetch_count_q;

  ptrp_result_t results_due[$];
  int           mismatch_count;

  // Advance the shadow state by one instruction and return its result
  function automatic ptrp_result_t predict_iot_result(ptrp_item_t item);
    ptrp_result_t      res;
    logic [DelayW-1:0] reload;
    res        = '0;
    res.ac_out = item.ac_in;
    reload     = (event_delay_q == '0) ? DelayW'(1) : event_delay_q;
    case (item.opcode)
      OP_TICK: begin
        if (punch_count_q != '0) begin
          punch_count_q = punch_count_q - 1'b1;
          if (punch_count_q == '0) punch_flag_q = 1'b1;
        end
        if (fetch_count_q != '0) begin
          fetch_count_q = fetch_count_q - 1'b1;
          if (fetch_count_q == '0) res.reader_request = 1'b1;
        end
      end
      OP_BYTE_IN: begin
        if (reader_flag_q) begin
          res.reader_rejected = 1'b1;
        end else begin
          reader_buffer_q = item.reader_char;
          reader_flag_q   = 1'b1;
        end
      end
      OP_INTR_ENABLE: intr_enable_q = 1'b1;
      OP_READER_SKIP: res.skip = reader_flag_q;
      OP_READ, OP_READ_FETCH: begin
        res.ac_write  = 1'b1;
        res.ac_out    = item.ac_in | AcW'(reader_buffer_q);
        reader_flag_q = 1'b0;
        if (item.opcode == OP_READ_FETCH) fetch_count_q = reload;
      end
      OP_FETCH: begin
        reader_flag_q = 1'b0;
        fetch_count_q = reload;
      end
      OP_INTR_DIS:    intr_enable_q = 1'b0;
      OP_PUNCH_SKIP:  res.skip = punch_flag_q;
      OP_PUNCH_CLEAR: punch_flag_q = 1'b0;
      OP_PUNCH, OP_CLEAR_PUNCH: begin
        if (item.opcode == OP_CLEAR_PUNCH) punch_flag_q = 1'b0;
        res.punch_valid = 1'b1;
        res.punch_byte  = item.ac_in[ByteW-1:0] & PunchMask;
        punch_count_q   = reload;
      end
      OP_DEV_CLEAR: begin
        reader_flag_q = 1'b0;
        punch_flag_q  = 1'b0;
        intr_enable_q = 1'b1;
      end
      default: ;
    endcase
    res.irq_reader = reader_flag_q & intr_enable_q;
    res.irq_punch  = punch_flag_q & intr_enable_q;
    return res;
  endfunction

  function automatic string show_result(ptrp_result_t r);
    return $sformatf("skip %0b acw %0b ac %03h punch %0b/%02h req %0b rej %0b irq %0b/%0b",
                     r.skip, r.ac_write, r.ac_out, r.punch_valid, r.punch_byte,
                     r.reader_request, r.reader_rejected, r.irq_reader, r.irq_punch);
  endfunction

  // Compare result transfers, then predict instruction transfers
  always @(posedge clk_i or negedge rst_ni) begin
    ptrp_result_t seen;
    ptrp_result_t due;
    ptrp_item_t   item;
    if (!rst_ni) begin
      event_delay_q   = DelayReset;
      reader_flag_q   = 1'b0;
      punch_flag_q    = 1'b0;
      intr_enable_q   = 1'b1;
      reader_buffer_q = '0;
      punch_count_q   = '0;
      fetch_count_q   = '0;
      mismatch_count  = 0;
      results_due.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        seen.skip            = skip_i;
        seen.ac_write        = ac_write_i;
        seen.ac_out          = ac_out_i;
        seen.punch_valid     = punch_valid_i;
        seen.punch_byte      = punch_byte_i;
        seen.reader_request  = reader_request_i;
        seen.reader_rejected = reader_rejected_i;
        seen.irq_reader      = irq_reader_i;
        seen.irq_punch       = irq_punch_i;
        if (results_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit)
            $display("%0t: result with none due: %s", $realtime, show_result(seen));
        end else begin
          due = results_due.pop_front();
          if (seen !== due) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected %s", show_result(due));
              $display("  actual   %s", show_result(seen));
            end
          end
        end
      end
      if (cfg_we_i) event_delay_q = cfg_wdata_i;
      if (in_valid_i && in_ready_i) begin
        item.opcode      = opcode_i;
        item.ac_in       = ac_in_i;
        item.reader_char = reader_char_i;
        results_due.push_back(predict_iot_result(item));
      end
      fail_count_o <= mismatch_count;
      pending_o    <= results_due.size();
    end
  end

endmodule

// ----- bench/paper_tape_reader_punch_iot_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paper_tape_reader_punch_iot_test
// Drives the reader/punch controller with random instruction streams and a
// directed instruction sequence under several event delays and handshake
// idling patterns; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module paper_tape_reader_punch_iot_test;
  import ptrp_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int HoldOffCycles = 48;
  localparam int HeavyIdlePct  = 65;
  localparam int LightIdlePct  = 18;
  localparam int ByteInPct     = 12;

  localparam logic [OpW-1:0] OpUnusedFirst = 4'd13;
  localparam logic [OpW-1:0] OpUnusedLast  = 4'd15;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [DelayW-1:0] cfg_wdata_i   = '0;
  logic              in_valid_i    = 1'b0;
  logic [OpW-1:0]    opcode_i      = '0;
  logic [AcW-1:0]    ac_in_i       = '0;
  logic [ByteW-1:0]  reader_char_i = '0;
  logic              out_ready_i   = 1'b0;
  logic              in_ready_o;
  logic              out_valid_o;
  logic              skip_o;
  logic              ac_write_o;
  logic [AcW-1:0]    ac_out_o;
  logic              punch_valid_o;
  logic [ByteW-1:0]  punch_byte_o;
  logic              reader_request_o;
  logic              reader_rejected_o;
  logic              irq_reader_o;
  logic              irq_punch_o;

  int iot_mismatches;
  int iot_pending;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_off_seq = 0;
  int quiet_cycles = 0;

  always #1 clk_i = ~clk_i;

  paper_tape_reader_punch_iot i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode_i),
    .ac_in_i          (ac_in_i),
    .reader_char_i    (reader_char_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .skip_o           (skip_o),
    .ac_write_o       (ac_write_o),
    .ac_out_o         (ac_out_o),
    .punch_valid_o    (punch_valid_o),
    .punch_byte_o     (punch_byte_o),
    .reader_request_o (reader_request_o),
    .reader_rejected_o(reader_rejected_o),
    .irq_reader_o     (irq_reader_o),
    .irq_punch_o      (irq_punch_o)
  );

  paper_tape_reader_punch_iot_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .opcode_i         (opcode_i),
    .ac_in_i          (ac_in_i),
    .reader_char_i    (reader_char_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .skip_i           (skip_o),
    .ac_write_i       (ac_write_o),
    .ac_out_i         (ac_out_o),
    .punch_valid_i    (punch_valid_o),
    .punch_byte_i     (punch_byte_o),
    .reader_request_i (reader_request_o),
    .reader_rejected_i(reader_rejected_o),
    .irq_reader_i     (irq_reader_o),
    .irq_punch_i      (irq_punch_o),
    .fail_count_o     (iot_mismatches),
    .pending_o        (iot_pending)
  );

  // Drop the run when neither channel has moved a transfer for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_seq != hold_seen) begin
        hold_seen = hold_off_seq;
        hold_left = HoldOffCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  function automatic ptrp_item_t instr(logic [OpW-1:0] op, logic [AcW-1:0] ac,
                                       logic [ByteW-1:0] ch);
    ptrp_item_t item;
    item.opcode      = op;
    item.ac_in       = ac;
    item.reader_char = ch;
    return item;
  endfunction

  // Pick an instruction: ticks at tick_pct and arriving bytes at ByteInPct, the rest spread out
  function automatic ptrp_item_t random_instr(int tick_pct);
    ptrp_item_t  item;
    int unsigned roll;
    roll = $urandom_range(99);
    if ($urandom_range(9) == 0) item.ac_in = $urandom_range(1) ? '1 : '0;
    else item.ac_in = AcW'($urandom);
    item.reader_char = ByteW'($urandom);
    if (roll < tick_pct) item.opcode = OP_TICK;
    else if (roll < tick_pct + ByteInPct) item.opcode = OP_BYTE_IN;
    else if ($urandom_range(29) == 0)
      item.opcode = OpW'($urandom_range(OpUnusedFirst, OpUnusedLast));
    else item.opcode = OpW'($urandom_range(OP_INTR_ENABLE, OP_DEV_CLEAR));
    return item;
  endfunction

  // Offer one instruction and hold it until it transfers
  task automatic send_item(input ptrp_item_t item);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    opcode_i      <= item.opcode;
    ac_in_i       <= item.ac_in;
    reader_char_i <= item.reader_char;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic feed_random(input int count, input int tick_pct);
    repeat (count) send_item(random_instr(tick_pct));
  endtask

  // Stop offering and wait for every predicted result
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (iot_pending != 0) @(negedge clk_i);
  endtask

  task automatic write_delay(input logic [DelayW-1:0] value);
    drain_results();
    repeat (3) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  initial begin : stimulus
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset delay, no idling
    set_idling(0, 0);
    feed_random(110, 35);

    // Directed sequence with the shortest delay
    write_delay(8'd1);
    send_item(instr(OP_DEV_CLEAR, '0, '0));
    send_item(instr(OP_BYTE_IN, '0, 8'hFF));
    send_item(instr(OP_BYTE_IN, '1, 8'h00));
    send_item(instr(OP_READER_SKIP, '0, '0));
    send_item(instr(OP_READ, 12'h000, '0));
    send_item(instr(OP_READER_SKIP, '0, '0));
    send_item(instr(OP_READ, 12'hF00, '0));
    send_item(instr(OP_PUNCH, 12'hFFF, '0));
    send_item(instr(OP_PUNCH_SKIP, '0, '0));
    send_item(instr(OP_TICK, '0, '0));
    send_item(instr(OP_PUNCH_SKIP, '0, '0));
    send_item(instr(OP_INTR_DIS, '0, '0));
    send_item(instr(OP_TICK, '0, '0));
    send_item(instr(OP_INTR_ENABLE, '0, '0));
    send_item(instr(OP_PUNCH_CLEAR, '0, '0));
    send_item(instr(OP_FETCH, '0, '0));
    send_item(instr(OP_TICK, '0, '0));
    send_item(instr(OP_READ_FETCH, 12'h000, '0));
    send_item(instr(OP_PUNCH, 12'h100, '0));
    send_item(instr(OP_CLEAR_PUNCH, 12'h0A5, '0));
    send_item(instr(OP_TICK, '0, '0));
    send_item(instr(OP_BYTE_IN, '0, 8'h5A));
    send_item(instr(OP_DEV_CLEAR, '0, '0));
    send_item(instr(OpUnusedFirst, 12'hABC, 8'h3C));
    send_item(instr(OpUnusedLast, '1, '1));

    // Zero delay behaves as one; sender idles
    set_idling(HeavyIdlePct, 0);
    write_delay(8'd0);
    feed_random(110, 35);

    // Receiver stalls, then holds off long enough to back up the input
    set_idling(0, HeavyIdlePct);
    write_delay(8'd2);
    feed_random(40, 35);
    hold_off_seq++;
    feed_random(70, 35);

    // Both sides idle; pause the sender until all results are back
    set_idling(LightIdlePct, LightIdlePct);
    write_delay(DelayW'($urandom_range(3, 12)));
    feed_random(50, 35);
    drain_results();
    feed_random(60, 35);

    // Longest delay: schedule both events and tick them to expiry
    set_idling(0, 0);
    write_delay(8'd255);
    send_item(instr(OP_READ_FETCH, AcW'($urandom), '0));
    send_item(instr(OP_PUNCH, AcW'($urandom), '0));
    repeat (260) send_item(instr(OP_TICK, AcW'($urandom), ByteW'($urandom)));
    feed_random(80, 35);

    set_idling(HeavyIdlePct, 0);
    write_delay(DelayW'($urandom_range(1, 6)));
    feed_random(110, 40);

    set_idling(0, HeavyIdlePct);
    write_delay(DelayW'($urandom_range(1, 255)));
    feed_random(110, 35);

    set_idling(LightIdlePct, LightIdlePct);
    write_delay(8'd3);
    feed_random(110, 30);

    // Long hold-off again with no idling around it
    set_idling(0, 0);
    feed_random(20, 35);
    hold_off_seq++;
    feed_random(40, 35);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (iot_mismatches == 0 && iot_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
